>>> rtl/sfbd_pkg.sv
// Package for the sprite frame blit decoder.
// Holds the shared constants, result and error codes and the header record type.
// Depends on nothing; used by every module of the block.
package sfbd_pkg;

  // Largest frame or canvas side and pixel count that the block supports.
  localparam logic [14:0] MAX_SIDE          = 15'd16384;
  localparam logic [26:0] MAX_CANVAS_PIXELS = 27'd67108864;

  // Fixed header words.
  localparam logic [31:0] BITS_PER_PIXEL = 32'd32;
  localparam logic [31:0] HEADER_MARKER  = 32'd8;
  localparam logic [31:0] MAX_VARIANT    = 32'd1;

  // Configuration register indexes.
  localparam logic CFG_SIDE_LIMIT  = 1'b0;
  localparam logic CFG_PIXEL_LIMIT = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_ACCEPT = 2'd0;
  localparam logic [1:0] KIND_REJECT = 2'd1;
  localparam logic [1:0] KIND_PIXEL  = 2'd2;

  // Error codes; lower codes take priority over higher ones.
  localparam logic [2:0] ERR_UNSUPPORTED = 3'd0;
  localparam logic [2:0] ERR_DIMENSIONS  = 3'd1;
  localparam logic [2:0] ERR_OUTSIDE     = 3'd2;
  localparam logic [2:0] ERR_IMAGE_SIZE  = 3'd3;
  localparam logic [2:0] ERR_CANVAS      = 3'd4;
  localparam logic [2:0] ERR_NONE        = 3'd7;

  // Decoder phases.
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_PIXELS = 2'd2;

  // Header word positions.
  localparam logic [3:0] POS_BPP     = 4'd0;
  localparam logic [3:0] POS_SIZE    = 4'd1;
  localparam logic [3:0] POS_FULL_W  = 4'd2;
  localparam logic [3:0] POS_FULL_H  = 4'd3;
  localparam logic [3:0] POS_FRAME_W = 4'd4;
  localparam logic [3:0] POS_FRAME_H = 4'd5;
  localparam logic [3:0] POS_LEFT    = 4'd6;
  localparam logic [3:0] POS_TOP     = 4'd7;
  localparam logic [3:0] POS_MARKER  = 4'd8;
  localparam logic [3:0] POS_VARIANT = 4'd9;

  // Collected header, handed to the judging logic on the final header word.
  typedef struct packed {
    logic [31:0] byte_size;
    logic [14:0] full_w;
    logic [14:0] full_h;
    logic [14:0] frame_w;
    logic [14:0] frame_h;
    logic [31:0] left;
    logic [31:0] top;
    logic [29:0] stored_px;
    logic [29:0] canvas_px;
    logic [2:0]  pend_err;
  } hdr_t;

endpackage

>>> rtl/sfbd_hdr_judge.sv
// Header judging logic of the sprite frame blit decoder.
// Turns a collected header and the pixel limit into an error code or ERR_NONE.
// Depends on sfbd_pkg.
module sfbd_hdr_judge (
  input  sfbd_pkg::hdr_t hdr_i,
  input  logic [26:0]    pixel_limit_i,
  output logic [2:0]     code_o
);

  logic [26:0] plim;
  logic [14:0] room_w;
  logic [14:0] room_h;
  logic        outside;
  logic        size_bad;
  logic        canvas_bad;

  // Clamp the pixel limit to the supported maximum.
  assign plim = (pixel_limit_i > sfbd_pkg::MAX_CANVAS_PIXELS) ?
                sfbd_pkg::MAX_CANVAS_PIXELS : pixel_limit_i;

  // Room left for the margins; only used when the frame fits in the canvas.
  assign room_w = hdr_i.full_w - hdr_i.frame_w;
  assign room_h = hdr_i.full_h - hdr_i.frame_h;

  // The frame must sit inside the canvas with non-negative margins.
  assign outside = (hdr_i.frame_w > hdr_i.full_w) || (hdr_i.frame_h > hdr_i.full_h) ||
                   hdr_i.left[31] || hdr_i.top[31] ||
                   (hdr_i.left > {17'd0, room_w}) || (hdr_i.top > {17'd0, room_h});

  // Stored pixels within the limit and four bytes per pixel.
  assign size_bad = (hdr_i.stored_px > {3'd0, plim}) ||
                    ({hdr_i.stored_px, 2'b00} != hdr_i.byte_size);

  assign canvas_bad = hdr_i.canvas_px > {3'd0, plim};

  // Checks in priority order.
  always_comb begin
    if (hdr_i.pend_err != sfbd_pkg::ERR_NONE) begin
      code_o = hdr_i.pend_err;
    end else if (outside) begin
      code_o = sfbd_pkg::ERR_OUTSIDE;
    end else if (size_bad) begin
      code_o = sfbd_pkg::ERR_IMAGE_SIZE;
    end else if (canvas_bad) begin
      code_o = sfbd_pkg::ERR_CANVAS;
    end else begin
      code_o = sfbd_pkg::ERR_NONE;
    end
  end

endmodule

>>> rtl/sprite_frame_blit_decoder.sv
// Top level of the sprite frame blit decoder.
// Collects the ten header words, judges them and places the following pixels.
// Depends on sfbd_pkg and sfbd_hdr_judge.

// The decoder takes one 32-bit word per clock cycle while its input is not
// stalled, and gives at most one result per word, in the cycle after the word
// is taken, from an output register. Header words other than the last give
// no result. A new word, header or pixel, can be taken while the previous
// result is taken from the output register. The canvas and frame pixel
// counts and the bottom row offset are multiplied out on earlier header
// words, so the tenth word only compares and adds. Input requests are stalled
// only while a result waits in the output register and the output is stalled.
// A word with frame_start_i high always begins a new header and drops any
// frame in progress; other words are ignored while the decoder is idle.
module sprite_frame_blit_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [26:0] cfg_wdata_i,
  // Input requests
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] word_i,
  input  logic        frame_start_i,
  // Result requests
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [2:0]  error_code_o,
  output logic [31:0] pixel_value_o,
  output logic [25:0] dest_index_o,
  output logic [14:0] canvas_width_o,
  output logic [14:0] canvas_height_o,
  output logic        last_pixel_o,
  output logic        frame_useful_o
);

  // Configuration registers
  logic [14:0] side_limit_q;
  logic [26:0] pixel_limit_q;

  // Control state
  logic [1:0]  phase_q, phase_d;
  logic [3:0]  pos_q, pos_d;
  logic [2:0]  pend_q, pend_d;
  logic [13:0] col_q, col_d;
  logic [13:0] row_q, row_d;
  logic [1:0]  vis_q, vis_d;

  // Header and frame registers
  logic [31:0] byte_size_q, byte_size_d;
  logic [14:0] full_w_q, full_w_d;
  logic [14:0] full_h_q, full_h_d;
  logic [14:0] frame_w_q, frame_w_d;
  logic [14:0] frame_h_q, frame_h_d;
  logic [31:0] left_q, left_d;
  logic [31:0] top_q, top_d;
  logic [29:0] stored_px_q, stored_px_d;
  logic [29:0] canvas_px_q, canvas_px_d;
  logic [25:0] bottom_term_q, bottom_term_d;
  logic [25:0] row_base_q, row_base_d;

  // Output register
  logic        out_valid_q, out_valid_d;
  logic [1:0]  kind_q, kind_d;
  logic [2:0]  err_q, err_d;
  logic [31:0] pixel_q, pixel_d;
  logic [25:0] dest_q, dest_d;
  logic [14:0] cw_q, cw_d;
  logic [14:0] ch_q, ch_d;
  logic        last_q, last_d;
  logic        useful_q, useful_d;

  // Working signals
  logic        accept;
  logic        out_take;
  logic [1:0]  eff_phase;
  logic [3:0]  eff_pos;
  logic [2:0]  eff_pend;
  logic [1:0]  eff_vis;
  logic [14:0] side_lim;
  logic        side_bad;
  logic [14:0] side_val;
  logic [2:0]  pend_var;
  logic [25:0] bottom_row;
  logic [25:0] bottom_prod;
  logic [14:0] col_p1;
  logic [14:0] row_p1;
  logic        is_last;
  logic [1:0]  vis_new;
  logic [2:0]  judge_code;
  sfbd_pkg::hdr_t hdr;

  assign accept     = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;
  assign in_stall_o = out_valid_q && out_stall_i;

  // A frame start restarts the header before the word is handled.
  assign eff_phase = frame_start_i ? sfbd_pkg::PH_HEADER : phase_q;
  assign eff_pos   = frame_start_i ? sfbd_pkg::POS_BPP   : pos_q;
  assign eff_pend  = frame_start_i ? sfbd_pkg::ERR_NONE  : pend_q;
  assign eff_vis   = frame_start_i ? 2'd0 : vis_q;

  // Side check for the four dimension words.
  assign side_lim = (side_limit_q > sfbd_pkg::MAX_SIDE) ? sfbd_pkg::MAX_SIDE : side_limit_q;
  assign side_bad = (word_i == 32'd0) || (word_i > {17'd0, side_lim});
  assign side_val = side_bad ? 15'd0 : word_i[14:0];

  // Pending error after the variant word has been looked at.
  assign pend_var = ((word_i > sfbd_pkg::MAX_VARIANT) &&
                     (sfbd_pkg::ERR_UNSUPPORTED < eff_pend)) ?
                    sfbd_pkg::ERR_UNSUPPORTED : eff_pend;

  // Offset of the bottom stored row in the canvas, formed on the marker word.
  // Only the low 26 bits of the index are kept, so the product is cut there.
  assign bottom_row  = top_q[25:0] + {11'd0, frame_h_q} - 26'd1;
  assign bottom_prod = bottom_row * {11'd0, full_w_q};

  // Pixel stepping.
  assign col_p1  = {1'b0, col_q} + 15'd1;
  assign row_p1  = {1'b0, row_q} + 15'd1;
  assign is_last = (col_p1 == frame_w_q) && (row_p1 == frame_h_q);
  assign vis_new = ((word_i[31:24] != 8'd0) && (eff_vis < 2'd2)) ? eff_vis + 2'd1 : eff_vis;

  // Header record for the judge.
  always_comb begin
    hdr.byte_size = byte_size_q;
    hdr.full_w    = full_w_q;
    hdr.full_h    = full_h_q;
    hdr.frame_w   = frame_w_q;
    hdr.frame_h   = frame_h_q;
    hdr.left      = left_q;
    hdr.top       = top_q;
    hdr.stored_px = stored_px_q;
    hdr.canvas_px = canvas_px_q;
    hdr.pend_err  = pend_var;
  end

  sfbd_hdr_judge u_judge (
    .hdr_i         (hdr),
    .pixel_limit_i (pixel_limit_q),
    .code_o        (judge_code)
  );

  // Next state and next result.
  always_comb begin
    phase_d       = phase_q;
    pos_d         = pos_q;
    pend_d        = pend_q;
    col_d         = col_q;
    row_d         = row_q;
    vis_d         = vis_q;
    byte_size_d   = byte_size_q;
    full_w_d      = full_w_q;
    full_h_d      = full_h_q;
    frame_w_d     = frame_w_q;
    frame_h_d     = frame_h_q;
    left_d        = left_q;
    top_d         = top_q;
    stored_px_d   = stored_px_q;
    canvas_px_d   = canvas_px_q;
    bottom_term_d = bottom_term_q;
    row_base_d    = row_base_q;

    out_valid_d = out_take ? 1'b0 : out_valid_q;
    kind_d      = kind_q;
    err_d       = err_q;
    pixel_d     = pixel_q;
    dest_d      = dest_q;
    cw_d        = cw_q;
    ch_d        = ch_q;
    last_d      = last_q;
    useful_d    = useful_q;

    if (accept) begin
      if (frame_start_i) begin
        phase_d = sfbd_pkg::PH_HEADER;
        pos_d   = sfbd_pkg::POS_BPP;
        pend_d  = sfbd_pkg::ERR_NONE;
        vis_d   = 2'd0;
      end
      case (eff_phase)
        sfbd_pkg::PH_HEADER: begin
          pos_d = eff_pos + 4'd1;
          case (eff_pos)
            sfbd_pkg::POS_BPP: begin
              if (word_i != sfbd_pkg::BITS_PER_PIXEL) begin
                pend_d = sfbd_pkg::ERR_UNSUPPORTED;
              end
            end
            sfbd_pkg::POS_SIZE: begin
              byte_size_d = word_i;
            end
            sfbd_pkg::POS_FULL_W: begin
              full_w_d = side_val;
              if (side_bad && (sfbd_pkg::ERR_DIMENSIONS < eff_pend)) begin
                pend_d = sfbd_pkg::ERR_DIMENSIONS;
              end
            end
            sfbd_pkg::POS_FULL_H: begin
              full_h_d = side_val;
              if (side_bad && (sfbd_pkg::ERR_DIMENSIONS < eff_pend)) begin
                pend_d = sfbd_pkg::ERR_DIMENSIONS;
              end
            end
            sfbd_pkg::POS_FRAME_W: begin
              frame_w_d   = side_val;
              canvas_px_d = {15'd0, full_w_q} * {15'd0, full_h_q};
              if (side_bad && (sfbd_pkg::ERR_DIMENSIONS < eff_pend)) begin
                pend_d = sfbd_pkg::ERR_DIMENSIONS;
              end
            end
            sfbd_pkg::POS_FRAME_H: begin
              frame_h_d = side_val;
              if (side_bad && (sfbd_pkg::ERR_DIMENSIONS < eff_pend)) begin
                pend_d = sfbd_pkg::ERR_DIMENSIONS;
              end
            end
            sfbd_pkg::POS_LEFT: begin
              left_d      = word_i;
              stored_px_d = {15'd0, frame_w_q} * {15'd0, frame_h_q};
            end
            sfbd_pkg::POS_TOP: begin
              top_d = word_i;
            end
            sfbd_pkg::POS_MARKER: begin
              bottom_term_d = bottom_prod;
              if (word_i != sfbd_pkg::HEADER_MARKER) begin
                pend_d = sfbd_pkg::ERR_UNSUPPORTED;
              end
            end
            default: begin
              // Variant word: judge the header and report.
              pos_d       = sfbd_pkg::POS_BPP;
              pend_d      = pend_var;
              out_valid_d = 1'b1;
              pixel_d     = 32'd0;
              dest_d      = 26'd0;
              last_d      = 1'b0;
              useful_d    = 1'b0;
              if (judge_code != sfbd_pkg::ERR_NONE) begin
                phase_d = sfbd_pkg::PH_IDLE;
                kind_d  = sfbd_pkg::KIND_REJECT;
                err_d   = judge_code;
                cw_d    = 15'd0;
                ch_d    = 15'd0;
              end else begin
                phase_d    = sfbd_pkg::PH_PIXELS;
                col_d      = 14'd0;
                row_d      = 14'd0;
                vis_d      = 2'd0;
                row_base_d = bottom_term_q + left_q[25:0];
                kind_d     = sfbd_pkg::KIND_ACCEPT;
                err_d      = 3'd0;
                cw_d       = full_w_q;
                ch_d       = full_h_q;
              end
            end
          endcase
        end
        sfbd_pkg::PH_PIXELS: begin
          // Place one pixel; step the column and move up one canvas row at
          // the end of each stored row.
          vis_d       = vis_new;
          out_valid_d = 1'b1;
          kind_d      = sfbd_pkg::KIND_PIXEL;
          err_d       = 3'd0;
          pixel_d     = word_i;
          dest_d      = row_base_q + {12'd0, col_q};
          cw_d        = 15'd0;
          ch_d        = 15'd0;
          last_d      = is_last;
          useful_d    = is_last && (vis_new == 2'd2);
          if (is_last) begin
            phase_d = sfbd_pkg::PH_IDLE;
          end else if (col_p1 >= frame_w_q) begin
            col_d      = 14'd0;
            row_d      = row_p1[13:0];
            row_base_d = row_base_q - {11'd0, full_w_q};
          end else begin
            col_d = col_p1[13:0];
          end
        end
        default: begin
          // Idle: the word is dropped.
        end
      endcase
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_limit_q  <= sfbd_pkg::MAX_SIDE;
      pixel_limit_q <= sfbd_pkg::MAX_CANVAS_PIXELS;
    end else if (cfg_we_i) begin
      if (cfg_index_i == sfbd_pkg::CFG_SIDE_LIMIT) begin
        side_limit_q <= cfg_wdata_i[14:0];
      end
      if (cfg_index_i == sfbd_pkg::CFG_PIXEL_LIMIT) begin
        pixel_limit_q <= cfg_wdata_i;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= sfbd_pkg::PH_IDLE;
      pos_q       <= sfbd_pkg::POS_BPP;
      pend_q      <= sfbd_pkg::ERR_NONE;
      col_q       <= 14'd0;
      row_q       <= 14'd0;
      vis_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      pend_q      <= pend_d;
      col_q       <= col_d;
      row_q       <= row_d;
      vis_q       <= vis_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Header, frame and result payload registers.
  always_ff @(posedge clk_i) begin
    byte_size_q   <= byte_size_d;
    full_w_q      <= full_w_d;
    full_h_q      <= full_h_d;
    frame_w_q     <= frame_w_d;
    frame_h_q     <= frame_h_d;
    left_q        <= left_d;
    top_q         <= top_d;
    stored_px_q   <= stored_px_d;
    canvas_px_q   <= canvas_px_d;
    bottom_term_q <= bottom_term_d;
    row_base_q    <= row_base_d;
    kind_q        <= kind_d;
    err_q         <= err_d;
    pixel_q       <= pixel_d;
    dest_q        <= dest_d;
    cw_q          <= cw_d;
    ch_q          <= ch_d;
    last_q        <= last_d;
    useful_q      <= useful_d;
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign error_code_o    = err_q;
  assign pixel_value_o   = pixel_q;
  assign dest_index_o    = dest_q;
  assign canvas_width_o  = cw_q;
  assign canvas_height_o = ch_q;
  assign last_pixel_o    = last_q;
  assign frame_useful_o  = useful_q;

  // The header position only moves while a header is being collected.
  a_pos_in_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != sfbd_pkg::PH_HEADER) |-> (pos_q == sfbd_pkg::POS_BPP))
    else $error("header position nonzero outside the header phase");

  // The final header word always yields a result in the next cycle.
  a_hdr_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !frame_start_i && (phase_q == sfbd_pkg::PH_HEADER) &&
     (pos_q == sfbd_pkg::POS_VARIANT)) |=> out_valid_q)
    else $error("no result after the final header word");

  // The column counter stays inside the stored row.
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == sfbd_pkg::PH_PIXELS) |-> ({1'b0, col_q} < frame_w_q))
    else $error("column counter beyond frame width");

  // Error codes and last pixel flags only travel with their own result kinds.
  a_fields_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (((kind_q == sfbd_pkg::KIND_REJECT) || (err_q == 3'd0)) &&
                     ((kind_q == sfbd_pkg::KIND_PIXEL) || !last_q)))
    else $error("result field set for the wrong result kind");

endmodule

>>> dv/tb_sprite_frame_blit_decoder.sv
// Self-checking testbench for the sprite frame blit decoder: random and directed frame
// records, a predictor class that works out every expected result, random idling.
// Depends on sfbd_pkg and the sprite_frame_blit_decoder RTL.
module tb_sprite_frame_blit_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;

  // One result request of the decoder.
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  error_code;
    logic [31:0] pixel_value;
    logic [25:0] dest_index;
    logic [14:0] canvas_width;
    logic [14:0] canvas_height;
    logic        last_pixel;
    logic        frame_useful;
  } blit_result_t;

  // Tracks the decoder state, predicts each result and checks results in order.
  class frame_blit_predictor;
    logic [14:0]  side_limit;
    logic [26:0]  pixel_limit;
    logic [1:0]   phase;
    logic [3:0]   header_pos;
    logic [2:0]   pend_err;
    logic [31:0]  byte_size;
    logic [14:0]  canvas_w;
    logic [14:0]  canvas_h;
    logic [14:0]  frame_w;
    logic [14:0]  frame_h;
    logic [31:0]  left_margin;
    logic [31:0]  top_margin;
    logic [13:0]  col;
    logic [13:0]  row;
    logic [25:0]  row_base;
    logic [1:0]   opaque_seen;
    blit_result_t awaited[$];
    int unsigned  mismatches;

    function new();
      side_limit  = sfbd_pkg::MAX_SIDE;
      pixel_limit = sfbd_pkg::MAX_CANVAS_PIXELS;
      phase       = sfbd_pkg::PH_IDLE;
      header_pos  = '0;
      pend_err    = sfbd_pkg::ERR_NONE;
      byte_size   = '0;
      canvas_w    = '0;
      canvas_h    = '0;
      frame_w     = '0;
      frame_h     = '0;
      left_margin = '0;
      top_margin  = '0;
      col         = '0;
      row         = '0;
      row_base    = '0;
      opaque_seen = '0;
      mismatches  = 0;
    endfunction

    function void write_limit(logic index, logic [26:0] value);
      if (index == sfbd_pkg::CFG_SIDE_LIMIT) begin
        side_limit = value[14:0];
      end else begin
        pixel_limit = value;
      end
    endfunction

    // Appends one prediction at the tail of the awaited list.
    function void queue_result(blit_result_t r);
      awaited = {awaited, r};
    endfunction

    // Lower codes win over higher ones.
    function void flag_error(logic [2:0] code);
      if (code < pend_err) begin
        pend_err = code;
      end
    endfunction

    function logic [14:0] take_side(logic [31:0] w);
      logic [14:0] lim;
      lim = (side_limit > sfbd_pkg::MAX_SIDE) ? sfbd_pkg::MAX_SIDE : side_limit;
      if (w == 32'd0 || w > {17'd0, lim}) begin
        flag_error(sfbd_pkg::ERR_DIMENSIONS);
        return '0;
      end
      return w[14:0];
    endfunction

    function logic [2:0] judge_header();
      logic [26:0] plim;
      logic [29:0] stored;
      logic [29:0] canvas;
      plim = (pixel_limit > sfbd_pkg::MAX_CANVAS_PIXELS) ? sfbd_pkg::MAX_CANVAS_PIXELS :
             pixel_limit;
      if (pend_err != sfbd_pkg::ERR_NONE) begin
        return pend_err;
      end
      if (frame_w > canvas_w || frame_h > canvas_h || left_margin[31] || top_margin[31] ||
          left_margin > ({17'd0, canvas_w} - {17'd0, frame_w}) ||
          top_margin > ({17'd0, canvas_h} - {17'd0, frame_h})) begin
        return sfbd_pkg::ERR_OUTSIDE;
      end
      stored = {15'd0, frame_w} * {15'd0, frame_h};
      if (stored > {3'd0, plim} || {stored, 2'b00} != byte_size) begin
        return sfbd_pkg::ERR_IMAGE_SIZE;
      end
      canvas = {15'd0, canvas_w} * {15'd0, canvas_h};
      if (canvas > {3'd0, plim}) begin
        return sfbd_pkg::ERR_CANVAS;
      end
      return sfbd_pkg::ERR_NONE;
    endfunction

    // Applies one accepted input request; returns 1 when the decoder acts on it.
    function bit note_word(logic [31:0] w, logic start);
      blit_result_t r;
      logic [3:0]   pos;
      logic [2:0]   code;
      logic [31:0]  bottom;
      logic [14:0]  next_col;
      logic         last;
      if (start) begin
        phase       = sfbd_pkg::PH_HEADER;
        header_pos  = '0;
        pend_err    = sfbd_pkg::ERR_NONE;
        opaque_seen = '0;
      end
      if (phase == sfbd_pkg::PH_IDLE) begin
        return 1'b0;
      end
      r = '0;
      if (phase == sfbd_pkg::PH_HEADER) begin
        pos        = header_pos;
        header_pos = pos + 4'd1;
        case (pos)
          sfbd_pkg::POS_BPP: begin
            if (w != sfbd_pkg::BITS_PER_PIXEL) flag_error(sfbd_pkg::ERR_UNSUPPORTED);
          end
          sfbd_pkg::POS_SIZE:    byte_size   = w;
          sfbd_pkg::POS_FULL_W:  canvas_w    = take_side(w);
          sfbd_pkg::POS_FULL_H:  canvas_h    = take_side(w);
          sfbd_pkg::POS_FRAME_W: frame_w     = take_side(w);
          sfbd_pkg::POS_FRAME_H: frame_h     = take_side(w);
          sfbd_pkg::POS_LEFT:    left_margin = w;
          sfbd_pkg::POS_TOP:     top_margin  = w;
          sfbd_pkg::POS_MARKER: begin
            if (w != sfbd_pkg::HEADER_MARKER) flag_error(sfbd_pkg::ERR_UNSUPPORTED);
          end
          default: begin
            // Variant word closes the header and the verdict goes out.
            if (w > sfbd_pkg::MAX_VARIANT) flag_error(sfbd_pkg::ERR_UNSUPPORTED);
            header_pos = '0;
            code = judge_header();
            if (code != sfbd_pkg::ERR_NONE) begin
              phase        = sfbd_pkg::PH_IDLE;
              r.kind       = sfbd_pkg::KIND_REJECT;
              r.error_code = code;
            end else begin
              phase       = sfbd_pkg::PH_PIXELS;
              col         = '0;
              row         = '0;
              opaque_seen = '0;
              bottom = (top_margin + {17'd0, frame_h} - 32'd1) * {17'd0, canvas_w} +
                       left_margin;
              row_base        = bottom[25:0];
              r.kind          = sfbd_pkg::KIND_ACCEPT;
              r.canvas_width  = canvas_w;
              r.canvas_height = canvas_h;
            end
            queue_result(r);
          end
        endcase
        return 1'b1;
      end
      // Pixel phase: rows run bottom-up through the canvas.
      last = ({1'b0, col} + 15'd1 == frame_w) && ({1'b0, row} + 15'd1 == frame_h);
      if (w[31:24] != 8'd0 && opaque_seen < 2'd2) begin
        opaque_seen = opaque_seen + 2'd1;
      end
      r.kind        = sfbd_pkg::KIND_PIXEL;
      r.pixel_value = w;
      r.dest_index  = row_base + {12'd0, col};
      if (last) begin
        r.last_pixel   = 1'b1;
        r.frame_useful = (opaque_seen >= 2'd2);
        phase          = sfbd_pkg::PH_IDLE;
      end else begin
        next_col = {1'b0, col} + 15'd1;
        if (next_col >= frame_w) begin
          col      = '0;
          row      = row + 14'd1;
          row_base = row_base - {11'd0, canvas_w};
        end else begin
          col = next_col[13:0];
        end
      end
      queue_result(r);
      return 1'b1;
    endfunction

    function string describe(blit_result_t r);
      return $sformatf("kind=%0d err=%0d px=%h idx=%h cw=%0d ch=%0d last=%0b useful=%0b",
                       r.kind, r.error_code, r.pixel_value, r.dest_index, r.canvas_width,
                       r.canvas_height, r.last_pixel, r.frame_useful);
    endfunction

    // Compares one accepted result request with the oldest prediction.
    function void check_result(blit_result_t got);
      blit_result_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", describe(got));
        return;
      end
      want = awaited.pop_front();
      if (got != want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected %s", describe(want));
          $display("          actual   %s", describe(got));
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [26:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] word_i = '0;
  logic        frame_start_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [2:0]  error_code_o;
  logic [31:0] pixel_value_o;
  logic [25:0] dest_index_o;
  logic [14:0] canvas_width_o;
  logic [14:0] canvas_height_o;
  logic        last_pixel_o;
  logic        frame_useful_o;

  frame_blit_predictor predictor = new();
  int unsigned         words_taken = 0;
  int unsigned         cycles = 0;
  int unsigned         send_idle_pct = 0;
  int unsigned         stall_pct = 0;
  logic [31:0]         hdr_words[10];

  sprite_frame_blit_decoder u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .word_i         (word_i),
    .frame_start_i  (frame_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .error_code_o   (error_code_o),
    .pixel_value_o  (pixel_value_o),
    .dest_index_o   (dest_index_o),
    .canvas_width_o (canvas_width_o),
    .canvas_height_o(canvas_height_o),
    .last_pixel_o   (last_pixel_o),
    .frame_useful_o (frame_useful_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Result side: random stalls and checking of every accepted result request.
  always @(posedge clk_i) begin
    blit_result_t got;
    out_stall_i <= ($urandom_range(99) < stall_pct);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.kind          = kind_o;
      got.error_code    = error_code_o;
      got.pixel_value   = pixel_value_o;
      got.dest_index    = dest_index_o;
      got.canvas_width  = canvas_width_o;
      got.canvas_height = canvas_height_o;
      got.last_pixel    = last_pixel_o;
      got.frame_useful  = frame_useful_o;
      predictor.check_result(got);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_sprite_frame_blit_decoder: FAIL");
      $finish;
    end
  end

  // Offers one input request, with random idle cycles first, and waits for it to go in.
  task automatic send_word(input logic [31:0] w, input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    word_i        <= w;
    frame_start_i <= start;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (predictor.note_word(w, start)) words_taken++;
  endtask

  // Lets every awaited result drain, then idles on for header words in flight.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (predictor.awaited.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes the side limit register, then the pixel limit register.
  task automatic set_limits(input logic [26:0] side, input logic [26:0] pixels);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= sfbd_pkg::CFG_SIDE_LIMIT;
    cfg_wdata_i <= side;
    @(posedge clk_i);
    predictor.write_limit(sfbd_pkg::CFG_SIDE_LIMIT, side);
    cfg_index_i <= sfbd_pkg::CFG_PIXEL_LIMIT;
    cfg_wdata_i <= pixels;
    @(posedge clk_i);
    predictor.write_limit(sfbd_pkg::CFG_PIXEL_LIMIT, pixels);
    cfg_we_i <= 1'b0;
  endtask

  function automatic void set_header(input logic [31:0] cw, input logic [31:0] ch,
                                     input logic [31:0] fw, input logic [31:0] fh,
                                     input logic [31:0] left, input logic [31:0] top,
                                     input logic [31:0] variant);
    hdr_words[sfbd_pkg::POS_BPP]     = sfbd_pkg::BITS_PER_PIXEL;
    hdr_words[sfbd_pkg::POS_SIZE]    = fw * fh * 32'd4;
    hdr_words[sfbd_pkg::POS_FULL_W]  = cw;
    hdr_words[sfbd_pkg::POS_FULL_H]  = ch;
    hdr_words[sfbd_pkg::POS_FRAME_W] = fw;
    hdr_words[sfbd_pkg::POS_FRAME_H] = fh;
    hdr_words[sfbd_pkg::POS_LEFT]    = left;
    hdr_words[sfbd_pkg::POS_TOP]     = top;
    hdr_words[sfbd_pkg::POS_MARKER]  = sfbd_pkg::HEADER_MARKER;
    hdr_words[sfbd_pkg::POS_VARIANT] = variant;
  endfunction

  task automatic send_header(input int count);
    for (int i = 0; i < count; i++) begin
      send_word(hdr_words[i], i == 0);
    end
  endtask

  task automatic send_pixels(input int count, input int clear_pct);
    logic [31:0] px;
    for (int i = 0; i < count; i++) begin
      px = $urandom();
      if ($urandom_range(99) < clear_pct) px[31:24] = 8'd0;
      send_word(px, 1'b0);
    end
  endtask

  // Full header, then the whole frame if the header is taken.
  task automatic run_record(input int clear_pct);
    send_header(10);
    if (predictor.phase == sfbd_pkg::PH_PIXELS) begin
      send_pixels(int'(predictor.frame_w) * int'(predictor.frame_h), clear_pct);
    end
  endtask

  task automatic random_record();
    int          fw;
    int          fh;
    int          cw;
    int          ch;
    int          roll;
    int          clear_pct;
    int          count;
    int          k;
    roll = $urandom_range(99);
    if ($urandom_range(9) == 0) begin
      fw = $urandom_range(1, 40);
      fh = $urandom_range(1, 2);
    end else begin
      fw = $urandom_range(1, 6);
      fh = $urandom_range(1, 5);
    end
    // Now and then a very wide canvas, to reach the high index bits.
    if ($urandom_range(9) == 0) begin
      cw = $urandom_range(fw, 16400);
      ch = fh + $urandom_range(0, 3);
    end else begin
      cw = fw + $urandom_range(0, 4);
      ch = fh + $urandom_range(0, 4);
    end
    set_header(cw, ch, fw, fh, $urandom_range(0, cw - fw), $urandom_range(0, ch - fh),
               $urandom_range(0, 1));
    case ($urandom_range(2))
      0:       clear_pct = 0;
      1:       clear_pct = 40;
      default: clear_pct = 95;
    endcase
    if (roll >= 70 && roll < 90) begin
      k = $urandom_range(0, 9);
      case ($urandom_range(3))
        0:       hdr_words[k] = $urandom();
        1:       hdr_words[k] = hdr_words[k] + 32'd1;
        2:       hdr_words[k] = hdr_words[k] - 32'd1;
        default: hdr_words[k] = hdr_words[k] | 32'h8000_0000;
      endcase
    end else if (roll >= 90 && roll < 95) begin
      // Header cut short; the next record restarts the decoder.
      send_header($urandom_range(1, 9));
      return;
    end else if (roll >= 95) begin
      for (int i = 0; i < 10; i++) begin
        if ($urandom_range(1) == 1) hdr_words[i] = $urandom();
      end
    end
    send_header(10);
    if (predictor.phase == sfbd_pkg::PH_PIXELS) begin
      count = int'(predictor.frame_w) * int'(predictor.frame_h);
      if (count > 1 && $urandom_range(11) == 0) count = $urandom_range(0, count - 1);
      send_pixels(count, clear_pct);
    end else if ($urandom_range(3) == 0) begin
      // Stray words after a rejection are ignored.
      send_pixels($urandom_range(1, 3), 50);
    end
  endtask

  task automatic directed_records();
    send_word(32'hDEAD_BEEF, 1'b0);
    // Single opaque pixel never counts as useful.
    set_header(1, 1, 1, 1, 0, 0, 0);
    run_record(0);
    set_header(5, 4, 3, 2, 1, 1, 1);
    run_record(50);
    // Unsupported headers: bit depth, marker, variant, and priority over bad sides.
    set_header(4, 4, 2, 2, 0, 0, 0);
    hdr_words[sfbd_pkg::POS_BPP] = 32'd24;
    run_record(0);
    set_header(4, 4, 2, 2, 0, 0, 0);
    hdr_words[sfbd_pkg::POS_MARKER] = 32'd9;
    run_record(0);
    set_header(4, 4, 2, 2, 0, 0, 2);
    run_record(0);
    set_header(4, 4, 0, 2, 0, 0, 0);
    hdr_words[sfbd_pkg::POS_BPP] = 32'd16;
    run_record(0);
    // Bad dimensions.
    set_header(4, 4, 0, 2, 0, 0, 0);
    run_record(0);
    set_header(16385, 4, 2, 2, 0, 0, 0);
    run_record(0);
    // Outside the canvas: too wide, negative margin, margin beyond the room left.
    set_header(2, 2, 3, 1, 0, 0, 0);
    run_record(0);
    set_header(4, 4, 2, 2, 32'h8000_0000, 0, 0);
    run_record(0);
    set_header(4, 4, 2, 2, 0, 3, 0);
    run_record(0);
    // Image size wrong, then stored frame over the pixel limit.
    set_header(4, 4, 2, 2, 0, 0, 0);
    hdr_words[sfbd_pkg::POS_SIZE] = hdr_words[sfbd_pkg::POS_SIZE] + 32'd4;
    run_record(0);
    set_header(16384, 16384, 16384, 16384, 0, 0, 0);
    run_record(0);
    // Canvas over the pixel limit, then the largest canvas that fits.
    set_header(16384, 16384, 1, 1, 0, 0, 0);
    run_record(0);
    set_header(16384, 4096, 2, 2, 16382, 4094, 1);
    run_record(30);
    // Restart during pixels and during the header.
    set_header(3, 3, 2, 2, 1, 0, 0);
    send_header(10);
    send_pixels(2, 0);
    set_header(2, 2, 2, 2, 0, 0, 0);
    send_header(5);
    set_header(3, 2, 2, 1, 1, 1, 0);
    run_record(100);
    send_word($urandom(), 1'b0);
    settle();
    // Zero side limit rejects everything.
    set_limits(27'd0, sfbd_pkg::MAX_CANVAS_PIXELS);
    set_header(2, 2, 1, 1, 0, 0, 0);
    run_record(0);
    settle();
    // Zero pixel limit rejects everything.
    set_limits(27'(sfbd_pkg::MAX_SIDE), 27'd0);
    run_record(0);
    settle();
    // Smallest working limits.
    set_limits(27'd1, 27'd1);
    set_header(1, 1, 1, 1, 0, 0, 0);
    run_record(0);
    set_header(2, 1, 1, 1, 0, 0, 0);
    run_record(0);
    settle();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // No idling, default limits written explicitly, directed records first.
    set_limits(27'(sfbd_pkg::MAX_SIDE), sfbd_pkg::MAX_CANVAS_PIXELS);
    directed_records();
    set_limits(27'(sfbd_pkg::MAX_SIDE), sfbd_pkg::MAX_CANVAS_PIXELS);
    while (words_taken < 400) random_record();

    // Sender idles often; limits above range count as the largest supported.
    settle();
    set_limits(27'h7FF_FFFF, 27'h7FF_FFFF);
    send_idle_pct = 69;
    while (words_taken < 800) random_record();

    // Receiver stalls often; tight limits give a mix of accepts and rejects.
    settle();
    set_limits(27'd6, 27'd20);
    send_idle_pct = 0;
    stall_pct = 69;
    while (words_taken < 1250) random_record();

    // Both sides idle; moderate random limits.
    settle();
    set_limits(27'($urandom_range(4, 12)), 27'($urandom_range(16, 100)));
    send_idle_pct = 35;
    stall_pct = 35;
    while (words_taken < 1650) random_record();

    in_valid_i <= 1'b0;
    while (predictor.awaited.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (predictor.mismatches == 0 && predictor.awaited.size() == 0) begin
      $display("tb_sprite_frame_blit_decoder: PASS");
    end else begin
      $display("tb_sprite_frame_blit_decoder: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/sfbd_pkg.sv
rtl/sfbd_hdr_judge.sv
rtl/sprite_frame_blit_decoder.sv
dv/tb_sprite_frame_blit_decoder.sv
